### design/imu_ahrs_frame_detector_assert.svh
// ----------------------------------------------------------------------------
// IMU/AHRS frame detector assertion macros
// Concurrent assertion wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef IMU_AHRS_FRAME_DETECTOR_ASSERT_SVH
`define IMU_AHRS_FRAME_DETECTOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IAFD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define IAFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/iafd_pkg.sv
// ----------------------------------------------------------------------------
// iafd_pkg
// Types and constants shared by the IMU/AHRS frame detector modules.
// ----------------------------------------------------------------------------
package iafd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef logic [BYTE_W-1:0] byte_t;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_BYTE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_BYTE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMU_TYPE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMU_LENGTH  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_AHRS_TYPE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_AHRS_LENGTH = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_IMU_BYTES   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_AHRS_BYTES  = 3'd7;

  // reset values
  localparam byte_t RST_HEAD_BYTE   = 8'd252;
  localparam byte_t RST_END_BYTE    = 8'd253;
  localparam byte_t RST_IMU_TYPE    = 8'd64;
  localparam byte_t RST_IMU_LENGTH  = 8'd56;
  localparam byte_t RST_AHRS_TYPE   = 8'd65;
  localparam byte_t RST_AHRS_LENGTH = 8'd48;
  localparam byte_t RST_IMU_BYTES   = 8'd64;
  localparam byte_t RST_AHRS_BYTES  = 8'd56;

  localparam byte_t POS_TYPE   = 8'd1;
  localparam byte_t POS_LENGTH = 8'd2;
  localparam byte_t POS_LAST   = 8'd255;

  typedef struct packed {
    byte_t head_byte;
    byte_t end_byte;
    byte_t imu_type_code;
    byte_t imu_length_code;
    byte_t ahrs_type_code;
    byte_t ahrs_length_code;
    byte_t imu_frame_bytes;
    byte_t ahrs_frame_bytes;
  } cfg_t;

  typedef struct packed {
    byte_t byte_out;
    byte_t frame_position;
    logic  in_frame;
    logic  imu_done;
    logic  imu_end_ok;
    logic  ahrs_done;
    logic  ahrs_end_ok;
  } result_t;

endpackage

### design/imu_ahrs_frame_detector.sv
// ----------------------------------------------------------------------------
// imu_ahrs_frame_detector
// Serial IMU/AHRS frame detector: input register, step logic, result register.
// ----------------------------------------------------------------------------
// Path: an accepted byte goes through the input register, then the result register.
// Throughput: one byte per cycle unless out_stall holds the result; input and
// result registers hold one byte each; a byte moves on when the result frees.
// Reset: synchronous; clears frame state, both pipeline valids, and loads the
// configuration registers with their default codes.
module imu_ahrs_frame_detector (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [iafd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  iafd_pkg::byte_t                  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  iafd_pkg::byte_t                  rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output iafd_pkg::byte_t                  byte_out,
  output iafd_pkg::byte_t                  frame_position,
  output logic                             in_frame,
  output logic                             imu_done,
  output logic                             imu_end_ok,
  output logic                             ahrs_done,
  output logic                             ahrs_end_ok
);
  import iafd_pkg::*;

  cfg_t    cfg;
  logic    hold_valid;
  byte_t   hold_byte;
  logic    advance;
  logic    in_xfer;
  result_t step_result;
  result_t result_reg;

  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;
  assign in_xfer  = in_valid && !in_stall;

  iafd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  iafd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step_en (advance),
    .rx_byte (hold_byte),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_xfer) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= step_result;
    end
  end

  assign byte_out       = result_reg.byte_out;
  assign frame_position = result_reg.frame_position;
  assign in_frame       = result_reg.in_frame;
  assign imu_done       = result_reg.imu_done;
  assign imu_end_ok     = result_reg.imu_end_ok;
  assign ahrs_done      = result_reg.ahrs_done;
  assign ahrs_end_ok    = result_reg.ahrs_end_ok;

endmodule

### design/iafd_cfg_regs.sv
// ----------------------------------------------------------------------------
// iafd_cfg_regs
// Configuration register file, written one register per cycle.
// ----------------------------------------------------------------------------
module iafd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [iafd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  iafd_pkg::byte_t                     cfg_data,
  output iafd_pkg::cfg_t                      cfg
);
  import iafd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_byte        <= RST_HEAD_BYTE;
      cfg.end_byte         <= RST_END_BYTE;
      cfg.imu_type_code    <= RST_IMU_TYPE;
      cfg.imu_length_code  <= RST_IMU_LENGTH;
      cfg.ahrs_type_code   <= RST_AHRS_TYPE;
      cfg.ahrs_length_code <= RST_AHRS_LENGTH;
      cfg.imu_frame_bytes  <= RST_IMU_BYTES;
      cfg.ahrs_frame_bytes <= RST_AHRS_BYTES;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HEAD_BYTE:   cfg.head_byte        <= cfg_data;
        REG_END_BYTE:    cfg.end_byte         <= cfg_data;
        REG_IMU_TYPE:    cfg.imu_type_code    <= cfg_data;
        REG_IMU_LENGTH:  cfg.imu_length_code  <= cfg_data;
        REG_AHRS_TYPE:   cfg.ahrs_type_code   <= cfg_data;
        REG_AHRS_LENGTH: cfg.ahrs_length_code <= cfg_data;
        REG_IMU_BYTES:   cfg.imu_frame_bytes  <= cfg_data;
        REG_AHRS_BYTES:  cfg.ahrs_frame_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### design/iafd_parser.sv
// ----------------------------------------------------------------------------
// iafd_parser
// Frame state and the per-byte step logic; state advances on step_en.
// ----------------------------------------------------------------------------
module iafd_parser (
  input  logic              clk,
  input  logic              rst,
  input  iafd_pkg::cfg_t    cfg,
  input  logic              step_en,
  input  iafd_pkg::byte_t   rx_byte,
  output iafd_pkg::result_t result
);
  import iafd_pkg::*;

  byte_t byte_count, byte_count_next;
  byte_t previous_byte;
  byte_t stored_type, stored_type_next;
  byte_t stored_length, stored_length_next;
  logic  imu_pending, imu_pending_next;
  logic  ahrs_pending, ahrs_pending_next;

  logic  counted;
  byte_t count_inc;
  byte_t count_after_imu;
  logic  imu_armed, ahrs_armed;
  logic  imu_hit, ahrs_hit;
  logic  byte_is_end;
  logic  last_kept;

  always_comb begin
    stored_type_next   = (byte_count == POS_TYPE)   ? rx_byte : stored_type;
    stored_length_next = (byte_count == POS_LENGTH) ? rx_byte : stored_length;

    counted   = ((previous_byte == cfg.end_byte) && (rx_byte == cfg.head_byte)) ||
                (byte_count != '0);
    count_inc = counted ? byte_t'(byte_count + 8'd1) : '0;

    imu_armed  = imu_pending  | (counted && (stored_type_next == cfg.imu_type_code) &&
                                (stored_length_next == cfg.imu_length_code));
    ahrs_armed = ahrs_pending | (counted && (stored_type_next == cfg.ahrs_type_code) &&
                                (stored_length_next == cfg.ahrs_length_code));

    // IMU check first; AHRS sees the count after an IMU clear
    imu_hit         = imu_armed && (count_inc == cfg.imu_frame_bytes);
    count_after_imu = imu_hit ? '0 : count_inc;
    ahrs_hit        = ahrs_armed && (count_after_imu == cfg.ahrs_frame_bytes);
    byte_count_next = ahrs_hit ? '0 : count_after_imu;

    imu_pending_next  = imu_armed  & ~imu_hit;
    ahrs_pending_next = ahrs_armed & ~ahrs_hit;

    // with a zero frame length the last byte is only known if it is this one
    byte_is_end = (rx_byte == cfg.end_byte);
    last_kept   = counted && (byte_count == POS_LAST);

    result.byte_out       = rx_byte;
    result.frame_position = byte_count;
    result.in_frame       = counted;
    result.imu_done       = imu_hit;
    result.imu_end_ok     = imu_hit && byte_is_end &&
                            ((cfg.imu_frame_bytes != '0) || last_kept);
    result.ahrs_done      = ahrs_hit;
    result.ahrs_end_ok    = ahrs_hit && byte_is_end &&
                            ((cfg.ahrs_frame_bytes != '0) || last_kept);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      previous_byte <= '0;
      stored_type   <= '0;
      stored_length <= '0;
      imu_pending   <= 1'b0;
      ahrs_pending  <= 1'b0;
    end else if (step_en) begin
      byte_count    <= byte_count_next;
      previous_byte <= rx_byte;
      stored_type   <= stored_type_next;
      stored_length <= stored_length_next;
      imu_pending   <= imu_pending_next;
      ahrs_pending  <= ahrs_pending_next;
    end
  end

endmodule

### design/iafd_checker.sv
// ----------------------------------------------------------------------------
// iafd_checker
// Port-level checks on the frame detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "imu_ahrs_frame_detector_assert.svh"

module iafd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input iafd_pkg::byte_t                  byte_out,
  input iafd_pkg::byte_t                  frame_position,
  input logic                             in_frame,
  input logic                             imu_done,
  input logic                             imu_end_ok,
  input logic                             ahrs_done,
  input logic                             ahrs_end_ok
);
  import iafd_pkg::*;

  // a stalled result holds
  `IAFD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(byte_out) && $stable(frame_position), "stalled result changed")

  // input only backs up behind a stalled result
  `IAFD_ASSERT_IMPL(a_in_stall, clk, rst, in_valid && in_stall, out_valid && out_stall, "input stalled with result register free")

  // end check only reported together with its done flag
  `IAFD_ASSERT_IMPL(a_imu_ok_done, clk, rst, out_valid && imu_end_ok, imu_done, "imu_end_ok without imu_done")

  `IAFD_ASSERT_IMPL(a_ahrs_ok_done, clk, rst, out_valid && ahrs_end_ok, ahrs_done, "ahrs_end_ok without ahrs_done")

  // a byte outside a frame can only be seen at position zero
  `IAFD_ASSERT_IMPL(a_idle_pos, clk, rst, out_valid && !in_frame, frame_position == '0, "uncounted byte at nonzero position")

endmodule

bind imu_ahrs_frame_detector iafd_checker u_iafd_checker (.*);

### bench/imu_ahrs_frame_checker.sv
// ----------------------------------------------------------------------------
// IMU/AHRS frame detector checker
// Watches the byte and report channels and the register port, keeps its own
// copy of the frame state, predicts one report per accepted byte and compares
// every accepted report with the oldest prediction.
// ----------------------------------------------------------------------------
module imu_ahrs_frame_checker import iafd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  byte_t                  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  byte_t                  rx_byte,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  byte_t                  byte_out,
  input  byte_t                  frame_position,
  input  logic                   in_frame,
  input  logic                   imu_done,
  input  logic                   imu_end_ok,
  input  logic                   ahrs_done,
  input  logic                   ahrs_end_ok,
  output int                     fail_count,
  output int                     outstanding,
  output int                     imu_frames,
  output int                     ahrs_frames
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t    codes;
  byte_t   count_q;
  byte_t   prev_q;
  byte_t   type_q;
  byte_t   length_q;
  logic    imu_armed;
  logic    ahrs_armed;
  result_t expected_reports[$];

  // end check of a finished frame; with a zero length the last byte is only
  // known when it was counted at the top position
  function automatic logic closes_on_end(byte_t total, byte_t cur, byte_t pos,
                                         logic counted);
    if (total != 8'd0) return cur == codes.end_byte;
    if (counted && pos == POS_LAST) return cur == codes.end_byte;
    return 1'b0;
  endfunction

  function automatic result_t predict_report(byte_t b);
    result_t r;
    byte_t   pos;
    logic    counted;
    r   = '0;
    pos = count_q;
    if (pos == POS_TYPE) type_q = b;
    if (pos == POS_LENGTH) length_q = b;
    counted = (prev_q == codes.end_byte && b == codes.head_byte) || pos != 8'd0;
    if (counted) begin
      count_q = pos + 8'd1;
      if (type_q == codes.imu_type_code && length_q == codes.imu_length_code)
        imu_armed = 1'b1;
      if (type_q == codes.ahrs_type_code && length_q == codes.ahrs_length_code)
        ahrs_armed = 1'b1;
    end else begin
      count_q = 8'd0;
    end
    prev_q = b;
    // IMU first; AHRS sees the count after any IMU clear
    if (imu_armed && count_q == codes.imu_frame_bytes) begin
      count_q      = 8'd0;
      imu_armed    = 1'b0;
      r.imu_done   = 1'b1;
      r.imu_end_ok = closes_on_end(codes.imu_frame_bytes, b, pos, counted);
    end
    if (ahrs_armed && count_q == codes.ahrs_frame_bytes) begin
      count_q       = 8'd0;
      ahrs_armed    = 1'b0;
      r.ahrs_done   = 1'b1;
      r.ahrs_end_ok = closes_on_end(codes.ahrs_frame_bytes, b, pos, counted);
    end
    r.byte_out       = b;
    r.frame_position = pos;
    r.in_frame       = counted;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    logic    bad;
    if (rst) begin
      codes = '{RST_HEAD_BYTE, RST_END_BYTE, RST_IMU_TYPE, RST_IMU_LENGTH,
                RST_AHRS_TYPE, RST_AHRS_LENGTH, RST_IMU_BYTES, RST_AHRS_BYTES};
      count_q    = 8'd0;
      prev_q     = 8'd0;
      type_q     = 8'd0;
      length_q   = 8'd0;
      imu_armed  = 1'b0;
      ahrs_armed = 1'b0;
      expected_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.byte_out       = byte_out;
        got.frame_position = frame_position;
        got.in_frame       = in_frame;
        got.imu_done       = imu_done;
        got.imu_end_ok     = imu_end_ok;
        got.ahrs_done      = ahrs_done;
        got.ahrs_end_ok    = ahrs_end_ok;
        if (got.imu_done === 1'b1) imu_frames++;
        if (got.ahrs_done === 1'b1) ahrs_frames++;
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected report: byte %h pos %0d", byte_out, frame_position);
        end else begin
          want = expected_reports.pop_front();
          bad  = (got.byte_out !== want.byte_out) ||
                 (got.frame_position !== want.frame_position) ||
                 (got.in_frame !== want.in_frame) ||
                 (got.imu_done !== want.imu_done) ||
                 (got.imu_end_ok !== want.imu_end_ok) ||
                 (got.ahrs_done !== want.ahrs_done) ||
                 (got.ahrs_end_ok !== want.ahrs_end_ok);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected byte %h pos %0d frame %b imu %b/%b ahrs %b/%b",
                        " | got byte %h pos %0d frame %b imu %b/%b ahrs %b/%b"},
                       want.byte_out, want.frame_position, want.in_frame,
                       want.imu_done, want.imu_end_ok, want.ahrs_done, want.ahrs_end_ok,
                       got.byte_out, got.frame_position, got.in_frame,
                       got.imu_done, got.imu_end_ok, got.ahrs_done, got.ahrs_end_ok);
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_HEAD_BYTE:   codes.head_byte        = cfg_data;
          REG_END_BYTE:    codes.end_byte         = cfg_data;
          REG_IMU_TYPE:    codes.imu_type_code    = cfg_data;
          REG_IMU_LENGTH:  codes.imu_length_code  = cfg_data;
          REG_AHRS_TYPE:   codes.ahrs_type_code   = cfg_data;
          REG_AHRS_LENGTH: codes.ahrs_length_code = cfg_data;
          REG_IMU_BYTES:   codes.imu_frame_bytes  = cfg_data;
          REG_AHRS_BYTES:  codes.ahrs_frame_bytes = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_reports.push_back(predict_report(rx_byte));
    end
    outstanding = expected_reports.size();
  end

endmodule

### bench/tb_imu_ahrs_frame_detector.sv
// ----------------------------------------------------------------------------
// IMU/AHRS frame detector testbench
// Drives directed and random serial byte streams through the detector under
// several register settings, with random idling on both channels, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_imu_ahrs_frame_detector import iafd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_HEAD_BYTE;
  byte_t                  cfg_data = 8'd0;
  logic                   in_valid = 1'b0;
  byte_t                  rx_byte = 8'd0;
  logic                   out_stall = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  byte_t                  byte_out;
  byte_t                  frame_position;
  logic                   in_frame;
  logic                   imu_done;
  logic                   imu_end_ok;
  logic                   ahrs_done;
  logic                   ahrs_end_ok;

  int    fail_count;
  int    outstanding;
  int    imu_frames;
  int    ahrs_frames;
  logic  quiet = 1'b0;
  cfg_t  cur;
  int    bytes_sent = 0;
  int    settings_used = 0;
  byte_t last_sent = 8'd0;
  int    stall_left = 0;
  int    idle_cycles = 0;

  imu_ahrs_frame_detector DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .rx_byte,
    .out_valid, .out_stall, .byte_out, .frame_position, .in_frame,
    .imu_done, .imu_end_ok, .ahrs_done, .ahrs_end_ok
  );

  imu_ahrs_frame_checker frame_check (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .rx_byte,
    .out_valid, .out_stall, .byte_out, .frame_position, .in_frame,
    .imu_done, .imu_end_ok, .ahrs_done, .ahrs_end_ok,
    .fail_count, .outstanding, .imu_frames, .ahrs_frames
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver backpressure in bursts
  always @(posedge clk) begin
    if (rst || quiet) stall_left = 0;
    else if (stall_left == 0 && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 9);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // one byte transfer, with an occasional sender gap first
  task automatic send_byte(input byte_t b);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
    last_sent = b;
  endtask

  // hold off until every report is back and the pipeline is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input byte_t val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_setting(input cfg_t c);
    write_reg(REG_HEAD_BYTE, c.head_byte);
    write_reg(REG_END_BYTE, c.end_byte);
    write_reg(REG_IMU_TYPE, c.imu_type_code);
    write_reg(REG_IMU_LENGTH, c.imu_length_code);
    write_reg(REG_AHRS_TYPE, c.ahrs_type_code);
    write_reg(REG_AHRS_LENGTH, c.ahrs_length_code);
    write_reg(REG_IMU_BYTES, c.imu_frame_bytes);
    write_reg(REG_AHRS_BYTES, c.ahrs_frame_bytes);
    cfg_write <= 1'b0;
    cur = c;
    settings_used++;
  endtask

  // end byte if needed, then head, type, length and a random body
  task automatic send_frame(input byte_t kind, input byte_t len, input byte_t total);
    int body;
    body = (total > 3) ? int'(total) - 3 : 0;
    if (total == 8'd0) body = 253;
    if (last_sent != cur.end_byte) send_byte(cur.end_byte);
    send_byte(cur.head_byte);
    send_byte(kind);
    send_byte(len);
    for (int k = 0; k < body; k++) begin
      if (k == body - 1 && $urandom_range(0, 1) == 1) send_byte(cur.end_byte);
      else send_byte(byte_t'($urandom));
    end
  endtask

  task automatic run_traffic(input int n_items);
    int stop;
    int pick;
    stop = bytes_sent + n_items;
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)
        send_frame(cur.imu_type_code, cur.imu_length_code, cur.imu_frame_bytes);
      else if (pick < 7)
        send_frame(cur.ahrs_type_code, cur.ahrs_length_code, cur.ahrs_frame_bytes);
      else if (pick == 7)
        repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom));
      else if (pick == 8)
        send_frame(byte_t'($urandom), cur.imu_length_code, byte_t'($urandom_range(3, 12)));
      else
        send_frame(cur.ahrs_type_code, byte_t'($urandom), byte_t'($urandom_range(3, 12)));
    end
  endtask

  function automatic cfg_t random_small_setting(input int lo, input int hi);
    cfg_t c;
    c.head_byte        = byte_t'($urandom);
    c.end_byte         = byte_t'($urandom);
    c.imu_type_code    = byte_t'($urandom);
    c.imu_length_code  = byte_t'($urandom);
    c.ahrs_type_code   = byte_t'($urandom);
    c.ahrs_length_code = byte_t'($urandom);
    c.imu_frame_bytes  = byte_t'($urandom_range(lo, hi));
    c.ahrs_frame_bytes = byte_t'($urandom_range(lo, hi));
    return c;
  endfunction

  initial begin : stimulus
    cfg_t  s;
    byte_t noise_seq[$] = '{8'h00, 8'hFF, 8'h5A, 8'hFD, 8'h00};
    byte_t frame_seq[$] = '{8'h5A, 8'hA5, 8'h01, 8'h06, 8'h33, 8'h5A,
                            8'hA5, 8'h02, 8'h05, 8'h44, 8'h00,
                            8'h00, 8'hA5, 8'hFF, 8'hFF};
    cur = '{RST_HEAD_BYTE, RST_END_BYTE, RST_IMU_TYPE, RST_IMU_LENGTH,
            RST_AHRS_TYPE, RST_AHRS_LENGTH, RST_IMU_BYTES, RST_AHRS_BYTES};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: end byte not followed by head opens nothing
    foreach (noise_seq[i]) send_byte(noise_seq[i]);
    wait_idle();

    // short frame: IMU closes on a head byte rather than the end byte; the AHRS bytes
    // after it and a head byte that does not follow an end byte open nothing
    s = '{head_byte: 8'hA5, end_byte: 8'h5A, imu_type_code: 8'h01, imu_length_code: 8'h06,
          ahrs_type_code: 8'h02, ahrs_length_code: 8'h05,
          imu_frame_bytes: 8'd6, ahrs_frame_bytes: 8'd5};
    load_setting(s);
    foreach (frame_seq[i]) send_byte(frame_seq[i]);
    wait_idle();

    s = '{RST_HEAD_BYTE, RST_END_BYTE, RST_IMU_TYPE, RST_IMU_LENGTH,
          RST_AHRS_TYPE, RST_AHRS_LENGTH, RST_IMU_BYTES, RST_AHRS_BYTES};
    load_setting(s);
    run_traffic(300);
    wait_idle();

    load_setting(random_small_setting(4, 12));
    run_traffic(200);
    wait_idle();
    run_traffic(200);
    wait_idle();

    // extremes: zero IMU length wraps the count, AHRS takes 255 bytes
    s = '{head_byte: 8'h00, end_byte: 8'hFF, imu_type_code: 8'hFF, imu_length_code: 8'h00,
          ahrs_type_code: 8'h00, ahrs_length_code: 8'hFF,
          imu_frame_bytes: 8'd0, ahrs_frame_bytes: 8'd255};
    load_setting(s);
    run_traffic(500);
    wait_idle();

    // shared codes arm both flags; zero AHRS length fires on the byte where IMU clears
    s = '{head_byte: 8'hFF, end_byte: 8'h00, imu_type_code: 8'h80, imu_length_code: 8'h7F,
          ahrs_type_code: 8'h80, ahrs_length_code: 8'h7F,
          imu_frame_bytes: 8'd5, ahrs_frame_bytes: 8'd0};
    load_setting(s);
    run_traffic(200);
    wait_idle();

    load_setting(random_small_setting(3, 4));
    quiet <= 1'b1;
    run_traffic(150);
    wait_idle();
    repeat (8) @(posedge clk);

    $display("summary: %0d bytes sent under %0d register settings", bytes_sent, settings_used);
    $display("summary: %0d imu and %0d ahrs frame completions reported",
             imu_frames, ahrs_frames);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### imu_ahrs_frame_detector.f
+incdir+design
design/iafd_pkg.sv
design/iafd_cfg_regs.sv
design/iafd_parser.sv
design/imu_ahrs_frame_detector.sv
design/iafd_checker.sv
bench/imu_ahrs_frame_checker.sv
bench/tb_imu_ahrs_frame_detector.sv
